// ===== rtl/rsu_pkg.sv =====
// Shared types and constants of the RV32I subset execute unit.
// No dependencies; used by every module of the unit.
`timescale 1ns / 1ps

package rsu_pkg;

    // Default sizes of the storage (MEM_DEPTH is a power of two)
    localparam int MEM_DEPTH_DEF = 4096;
    localparam int REG_COUNT_DEF = 32;

    // Field widths
    localparam int XLEN      = 32;
    localparam int REG_IDX_W = 5;
    localparam int OFFSET_W  = 7;
    localparam int TARGET_W  = 12;
    localparam int PC_OUT_W  = 12;
    localparam int OP_W      = 4;

    // Stream and configuration widths
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 5;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;
    localparam int CFG_W     = 12;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_ADDI = 4'd2,
        OP_BNE  = 4'd3,
        OP_BLT  = 4'd4,
        OP_BEQ  = 4'd5,
        OP_LW   = 4'd6,
        OP_SW   = 4'd7,
        OP_J    = 4'd8,
        OP_JAL  = 4'd9,
        OP_LA   = 4'd10,
        OP_LI   = 4'd11,
        OP_NOP  = 4'd12
    } op_t;

    // Fold a 5-bit register index into the range of the register file
    function automatic logic [REG_IDX_W-1:0] reg_wrap(input logic [REG_IDX_W-1:0] idx,
                                                      input int count);
        logic [REG_IDX_W:0] v;
        v = {1'b0, idx};
        for (int i = 0; i < 4; i++)
        begin
            if (v >= (REG_IDX_W+1)'(count))
            begin
                v = v - (REG_IDX_W+1)'(count);
            end
        end
        return v[REG_IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/riscv_subset_execute_unit.sv =====
// Top level of the RV32I subset execute unit: two-stage pipeline around the
// register file and data memory. Depends on rsu_pkg, rsu_regfile, rsu_dmem.
//
//  channel  | direction | signals                                  | purpose
//  ---------+-----------+------------------------------------------+--------------------------
//  cfg      | in        | cfg_we, cfg_wdata                        | start_pc write
//  s_axis   | in        | s_axis_tvalid/tready/tdata/tuser         | pre-decoded instruction
//  m_axis   | out       | m_axis_tvalid/tready/tdata/tuser         | execution result
//
// One item per cycle while no clearing pass runs and results are taken; a result
// is offered from stage 2 once its item moves on from stage 1. Stage 1 reads the
// register file (registered read), stage 2 holds the result and the data memory
// read word; forwarding covers writes still in flight. After reset a clearing pass
// runs over the MEM_DEPTH word valid marks while no item is accepted. A stalled
// result holds both stages; an empty first stage still takes an item.
`timescale 1ns / 1ps

module riscv_subset_execute_unit #(
    parameter int MEM_DEPTH = rsu_pkg::MEM_DEPTH_DEF,
    parameter int REG_COUNT = rsu_pkg::REG_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // start_pc
    input  logic                          cfg_we,
    input  logic [rsu_pkg::CFG_W-1:0]     cfg_wdata,
    // tdata: dest_reg, src_a_reg, src_b_reg, immediate, mem_offset, target_addr
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rsu_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: operation, offset_given
    input  logic [rsu_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // tdata: next_pc, written_index, written_value
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rsu_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: reg_written, branch_taken, address_fault
    output logic [rsu_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    localparam int AW   = $clog2(MEM_DEPTH);
    localparam int RW   = $clog2(REG_COUNT);
    localparam int XLEN = rsu_pkg::XLEN;
    localparam int RIW  = rsu_pkg::REG_IDX_W;

    // Input unpacking
    logic [rsu_pkg::OP_W-1:0]     in_op;
    logic                         in_given;
    logic [RIW-1:0]               in_rd_raw;
    logic [RIW-1:0]               in_ra_raw;
    logic [RIW-1:0]               in_rb_raw;
    logic [RIW-1:0]               in_rd_w;
    logic [RIW-1:0]               in_ra_w;
    logic [RIW-1:0]               in_rb_w;
    logic [XLEN-1:0]              in_imm;
    logic [rsu_pkg::OFFSET_W-1:0] in_off;
    logic [XLEN-1:0]              in_tgt32;
    logic [XLEN-1:0]              cfg_pc32;
    logic                         in_is_br;
    logic                         in_fire;

    // Control
    logic clear_busy;
    logic pipe_en;
    logic s1_adv;

    // Stage 1
    logic                     s1_valid_reg;
    logic [rsu_pkg::OP_W-1:0] s1_op_reg;
    logic                     s1_given_reg;
    logic [RW-1:0]            s1_rd_reg;
    logic [RW-1:0]            s1_pa_reg;
    logic [RW-1:0]            s1_pb_reg;
    logic [XLEN-1:0]          s1_imm_reg;
    logic [rsu_pkg::OFFSET_W-1:0] s1_off_reg;
    logic [AW-1:0]            s1_tgt_reg;
    logic [AW-1:0]            pc_reg;
    logic [AW-1:0]            pc_next;

    // Register file ports
    logic [XLEN-1:0] rf_data_a;
    logic [XLEN-1:0] rf_data_b;
    logic            rf_we;

    // Last register write, for items that read at the same edge
    logic            w3_valid_reg;
    logic [RW-1:0]   w3_idx_reg;
    logic [XLEN-1:0] w3_val_reg;

    // Execute
    logic [XLEN-1:0] va;
    logic [XLEN-1:0] vb;
    logic            ex_wr;
    logic [XLEN-1:0] ex_val;
    logic            ex_taken;
    logic            ex_fault;
    logic            ex_load;
    logic            ex_store;
    logic [XLEN+1:0] ea;
    logic            ea_bad;

    // Stage 2
    logic            s2_valid_reg;
    logic            s2_wr_reg;
    logic            s2_load_reg;
    logic [RW-1:0]   s2_idx_reg;
    logic [XLEN-1:0] s2_val_reg;
    logic            s2_taken_reg;
    logic            s2_fault_reg;
    logic [AW-1:0]   s2_pc_reg;
    logic            s2_wr;
    logic [XLEN-1:0] s2_wval;

    // Data memory ports
    logic [XLEN-1:0] dm_rd_data;
    logic            dm_rd_valid;

    // Output shaping
    logic [XLEN-1:0]             out_pc32;
    logic [RIW-1:0]              out_idx;
    logic [XLEN-1:0]             out_val;

    // Unpack the input item
    assign in_op     = s_axis_tuser[3:0];
    assign in_given  = s_axis_tuser[4];
    assign in_rd_raw = s_axis_tdata[4:0];
    assign in_ra_raw = s_axis_tdata[9:5];
    assign in_rb_raw = s_axis_tdata[14:10];
    assign in_imm    = s_axis_tdata[46:15];
    assign in_off    = s_axis_tdata[53:47];
    assign in_tgt32  = XLEN'(s_axis_tdata[65:54]);
    assign cfg_pc32  = XLEN'(cfg_wdata);

    assign in_rd_w = rsu_pkg::reg_wrap(in_rd_raw, REG_COUNT);
    assign in_ra_w = rsu_pkg::reg_wrap(in_ra_raw, REG_COUNT);
    assign in_rb_w = rsu_pkg::reg_wrap(in_rb_raw, REG_COUNT);

    assign in_is_br = in_op inside {rsu_pkg::OP_BNE, rsu_pkg::OP_BLT, rsu_pkg::OP_BEQ};

    // Advance when the result register is free or being taken
    assign pipe_en       = !s2_valid_reg || m_axis_tready;
    assign s1_adv        = s1_valid_reg && pipe_en;
    assign s_axis_tready = !clear_busy && (!s1_valid_reg || pipe_en);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Register file: branches compare dest and src_a, others read src_a and src_b
    rsu_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_fire),
        .rd_addr_a (in_is_br ? in_rd_w[RW-1:0] : in_ra_w[RW-1:0]),
        .rd_addr_b (in_is_br ? in_ra_w[RW-1:0] : in_rb_w[RW-1:0]),
        .rd_data_a (rf_data_a),
        .rd_data_b (rf_data_b),
        .wr_en     (rf_we),
        .wr_addr   (s2_idx_reg),
        .wr_data   (s2_wval)
    );

    // Stage 1 valid and program counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pc_reg       <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                pc_reg <= cfg_pc32[AW-1:0];
            end
            else if (s1_adv)
            begin
                pc_reg <= pc_next;
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg    <= in_op;
            s1_given_reg <= in_given;
            s1_rd_reg    <= in_rd_w[RW-1:0];
            s1_pa_reg    <= in_is_br ? in_rd_w[RW-1:0] : in_ra_w[RW-1:0];
            s1_pb_reg    <= in_is_br ? in_ra_w[RW-1:0] : in_rb_w[RW-1:0];
            s1_imm_reg   <= in_imm;
            s1_off_reg   <= in_off;
            s1_tgt_reg   <= in_tgt32[AW-1:0];
        end
    end

    // Forward writes in flight: result stage first, then the last write
    always_comb
    begin
        if (s2_wr && s2_idx_reg == s1_pa_reg)
        begin
            va = s2_wval;
        end
        else if (w3_valid_reg && w3_idx_reg == s1_pa_reg)
        begin
            va = w3_val_reg;
        end
        else
        begin
            va = rf_data_a;
        end
        if (s2_wr && s2_idx_reg == s1_pb_reg)
        begin
            vb = s2_wval;
        end
        else if (w3_valid_reg && w3_idx_reg == s1_pb_reg)
        begin
            vb = w3_val_reg;
        end
        else
        begin
            vb = rf_data_b;
        end
    end

    // Effective address for loads and stores
    assign ea     = {{2{va[XLEN-1]}}, va} + (XLEN+2)'(s1_off_reg);
    assign ea_bad = ea[XLEN+1] || (ea >= (XLEN+2)'(MEM_DEPTH));

    // Execute the instruction in stage 1
    always_comb
    begin
        ex_wr    = 1'b0;
        ex_val   = '0;
        ex_taken = 1'b0;
        ex_fault = 1'b0;
        ex_load  = 1'b0;
        ex_store = 1'b0;
        case (s1_op_reg)
            rsu_pkg::OP_ADD:
            begin
                ex_wr  = 1'b1;
                ex_val = va + vb;
            end
            rsu_pkg::OP_SUB:
            begin
                ex_wr  = 1'b1;
                ex_val = va - vb;
            end
            rsu_pkg::OP_ADDI:
            begin
                ex_wr  = 1'b1;
                ex_val = va + s1_imm_reg;
            end
            rsu_pkg::OP_BNE:  ex_taken = (va != vb);
            rsu_pkg::OP_BLT:  ex_taken = ($signed(va) < $signed(vb));
            rsu_pkg::OP_BEQ:  ex_taken = (va == vb);
            rsu_pkg::OP_LW:
            begin
                if (s1_given_reg)
                begin
                    ex_fault = ea_bad;
                    ex_load  = !ea_bad;
                end
            end
            rsu_pkg::OP_SW:
            begin
                if (s1_given_reg)
                begin
                    ex_fault = ea_bad;
                    ex_store = !ea_bad;
                end
            end
            rsu_pkg::OP_J:    ex_taken = 1'b1;
            rsu_pkg::OP_JAL:
            begin
                ex_wr    = 1'b1;
                ex_val   = XLEN'(pc_reg) + 1'b1;
                ex_taken = 1'b1;
            end
            rsu_pkg::OP_LA:
            begin
                ex_wr  = 1'b1;
                ex_val = XLEN'(s1_tgt_reg);
            end
            rsu_pkg::OP_LI:
            begin
                ex_wr  = 1'b1;
                ex_val = s1_imm_reg;
            end
            default:
            begin
                ex_wr = 1'b0;
            end
        endcase
    end

    // Next program counter
    assign pc_next = ex_taken ? s1_tgt_reg : pc_reg + 1'b1;

    // Data memory: access at the edge that moves the item to stage 2
    rsu_dmem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dmem (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear_busy (clear_busy),
        .rd_en      (s1_adv && ex_load),
        .wr_en      (s1_adv && ex_store),
        .addr       (ea[AW-1:0]),
        .wr_data    (vb),
        .rd_data    (dm_rd_data),
        .rd_valid   (dm_rd_valid)
    );

    // Stage 2 valid and last-write record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            w3_valid_reg <= 1'b0;
        end
        else
        begin
            if (pipe_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rf_we)
            begin
                w3_valid_reg <= 1'b1;
            end
        end
    end

    // Stage 2 payload and last-write data
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_wr_reg    <= ex_wr;
            s2_load_reg  <= ex_load;
            s2_idx_reg   <= s1_rd_reg;
            s2_val_reg   <= ex_val;
            s2_taken_reg <= ex_taken;
            s2_fault_reg <= ex_fault;
            s2_pc_reg    <= pc_next;
        end
        if (rf_we)
        begin
            w3_idx_reg <= s2_idx_reg;
            w3_val_reg <= s2_wval;
        end
    end

    // A load writes only when the word was written before
    assign s2_wr   = s2_valid_reg && (s2_wr_reg || (s2_load_reg && dm_rd_valid));
    assign s2_wval = s2_load_reg ? dm_rd_data : s2_val_reg;
    assign rf_we   = pipe_en && s2_wr;

    // Pack the result item
    assign out_pc32 = XLEN'(s2_pc_reg);
    assign out_idx  = s2_wr ? RIW'(s2_idx_reg) : '0;
    assign out_val  = s2_wr ? s2_wval : '0;

    assign m_axis_tvalid = s2_valid_reg;
    assign m_axis_tdata  = {7'd0, out_val, out_idx, out_pc32[rsu_pkg::PC_OUT_W-1:0]};
    assign m_axis_tuser  = {s2_fault_reg, s2_taken_reg, s2_wr};

endmodule

// ===== rtl/rsu_regfile.sv =====
// Register file of the execute unit: two registered read ports, one write port.
// Entries read as zero until first written (per-entry valid flops). Uses rsu_pkg.
`timescale 1ns / 1ps

module rsu_regfile #(
    parameter int REG_COUNT = rsu_pkg::REG_COUNT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [$clog2(REG_COUNT)-1:0] rd_addr_a,
    input  logic [$clog2(REG_COUNT)-1:0] rd_addr_b,
    output logic [rsu_pkg::XLEN-1:0]   rd_data_a,
    output logic [rsu_pkg::XLEN-1:0]   rd_data_b,
    input  logic                       wr_en,
    input  logic [$clog2(REG_COUNT)-1:0] wr_addr,
    input  logic [rsu_pkg::XLEN-1:0]   wr_data
);

    logic [rsu_pkg::XLEN-1:0] regs_mem [REG_COUNT];
    logic [REG_COUNT-1:0]     valid_reg;
    logic [rsu_pkg::XLEN-1:0] data_a_reg;
    logic [rsu_pkg::XLEN-1:0] data_b_reg;
    logic                     va_reg;
    logic                     vb_reg;

    // Mark entries as written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                va_reg <= valid_reg[rd_addr_a];
                vb_reg <= valid_reg[rd_addr_b];
            end
        end
    end

    // Storage array: write, and read old data on a same-edge write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            regs_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_a_reg <= regs_mem[rd_addr_a];
            data_b_reg <= regs_mem[rd_addr_b];
        end
    end

    // Unwritten entries read as zero
    assign rd_data_a = va_reg ? data_a_reg : '0;
    assign rd_data_b = vb_reg ? data_b_reg : '0;

endmodule

// ===== rtl/rsu_dmem.sv =====
// Data word memory of the execute unit with a valid mark per word.
// Sweeps the valid marks clear after reset, one word a cycle. Uses rsu_pkg.
`timescale 1ns / 1ps

module rsu_dmem #(
    parameter int MEM_DEPTH = rsu_pkg::MEM_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    output logic                         clear_busy,
    input  logic                         rd_en,
    input  logic                         wr_en,
    input  logic [$clog2(MEM_DEPTH)-1:0] addr,
    input  logic [rsu_pkg::XLEN-1:0]     wr_data,
    output logic [rsu_pkg::XLEN-1:0]     rd_data,
    output logic                         rd_valid
);

    localparam int AW = $clog2(MEM_DEPTH);

    logic [rsu_pkg::XLEN-1:0] data_mem  [MEM_DEPTH];
    logic                     valid_mem [MEM_DEPTH];
    logic                     clr_busy_reg;
    logic [AW-1:0]            clr_addr_reg;
    logic [rsu_pkg::XLEN-1:0] rd_data_reg;
    logic                     rd_valid_reg;

    // Step the clearing pass through every word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(MEM_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Write port: clearing pass or store
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            valid_mem[clr_addr_reg] <= 1'b0;
        end
        else if (wr_en)
        begin
            data_mem[addr]  <= wr_data;
            valid_mem[addr] <= 1'b1;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= data_mem[addr];
            rd_valid_reg <= valid_mem[addr];
        end
    end

    assign clear_busy = clr_busy_reg;
    assign rd_data    = rd_data_reg;
    assign rd_valid   = rd_valid_reg;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for riscv_subset_execute_unit: a directed sequence,
// then random instruction streams under several start PCs. Depends on rsu_pkg.
`timescale 1ns / 1ps

module testbench;

    localparam int MEM_WORDS     = rsu_pkg::MEM_DEPTH_DEF;
    localparam int REGS          = rsu_pkg::REG_COUNT_DEF;
    localparam int IDLE_LIMIT    = 20000;   // covers the clearing pass after reset
    localparam int HOLD_AT       = 120;     // instruction count that starts the long stall
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 10;

    // One pre-decoded instruction and the outcome it should produce
    typedef struct {
        logic [3:0]  op;
        logic [4:0]  rd;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [31:0] imm;
        logic [6:0]  off;
        logic        given;
        logic [11:0] tgt;
    } instr_t;

    typedef struct {
        logic [11:0] npc;
        logic        wr;
        logic [4:0]  widx;
        logic [31:0] wval;
        logic        taken;
        logic        fault;
    } outcome_t;

    typedef struct {
        instr_t   ins;
        outcome_t res;
    } job_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [rsu_pkg::CFG_W-1:0]       cfg_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [rsu_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [rsu_pkg::S_TUSER_W-1:0]   s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [rsu_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic [rsu_pkg::M_TUSER_W-1:0]   m_axis_tuser;

    // Architectural state as the unit should see it
    logic [31:0] arch_regs [0:REGS-1];
    logic [11:0] arch_pc;
    logic [31:0] data_mem [0:MEM_WORDS-1];
    bit          data_mem_valid [0:MEM_WORDS-1];

    job_t     pending_instrs [$];
    outcome_t expected_results [$];
    job_t     cur_job;

    int unsigned queued_instrs = 0;
    int unsigned accepted_instrs = 0;
    int unsigned results_seen = 0;
    int unsigned errors = 0;
    int unsigned load_hits = 0;
    int unsigned addr_faults = 0;
    int unsigned redirects = 0;
    int unsigned pc_settings = 0;
    int unsigned send_gap = 0;
    int unsigned recv_wait = 0;
    int unsigned hold_left = 0;
    int unsigned idle_cycles = 0;
    bit          send_steady = 1'b0;
    bit          recv_steady = 1'b0;
    bit          hold_done = 1'b0;

    riscv_subset_execute_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Execute one instruction against the architectural state
    function automatic outcome_t execute_instr(instr_t it);
        outcome_t o;
        logic     cond;
        longint   ea;
        o = '{default: '0};
        o.npc = arch_pc + 12'd1;
        cond = 1'b0;
        case (it.op)
            rsu_pkg::OP_ADD:
            begin
                o.wr = 1'b1; o.widx = it.rd; o.wval = arch_regs[it.ra] + arch_regs[it.rb];
            end
            rsu_pkg::OP_SUB:
            begin
                o.wr = 1'b1; o.widx = it.rd; o.wval = arch_regs[it.ra] - arch_regs[it.rb];
            end
            rsu_pkg::OP_ADDI:
            begin
                o.wr = 1'b1; o.widx = it.rd; o.wval = arch_regs[it.ra] + it.imm;
            end
            rsu_pkg::OP_BNE: cond = arch_regs[it.rd] != arch_regs[it.ra];
            rsu_pkg::OP_BLT: cond = $signed(arch_regs[it.rd]) < $signed(arch_regs[it.ra]);
            rsu_pkg::OP_BEQ: cond = arch_regs[it.rd] == arch_regs[it.ra];
            rsu_pkg::OP_LW, rsu_pkg::OP_SW:
            begin
                if (it.given)
                begin
                    ea = longint'($signed(arch_regs[it.ra])) + longint'(it.off);
                    if (ea < 0 || ea >= MEM_WORDS)
                    begin
                        o.fault = 1'b1;
                    end
                    else if (it.op == rsu_pkg::OP_LW)
                    begin
                        if (data_mem_valid[ea])
                        begin
                            o.wr = 1'b1; o.widx = it.rd; o.wval = data_mem[ea];
                        end
                    end
                    else
                    begin
                        data_mem[ea] = arch_regs[it.rb];
                        data_mem_valid[ea] = 1'b1;
                    end
                end
            end
            rsu_pkg::OP_J: o.taken = 1'b1;
            rsu_pkg::OP_JAL:
            begin
                // link is the old pc plus one, without wrap
                o.wr = 1'b1; o.widx = it.rd; o.wval = {20'd0, arch_pc} + 32'd1;
                o.taken = 1'b1;
            end
            rsu_pkg::OP_LA:
            begin
                o.wr = 1'b1; o.widx = it.rd; o.wval = {20'd0, it.tgt};
            end
            rsu_pkg::OP_LI:
            begin
                o.wr = 1'b1; o.widx = it.rd; o.wval = it.imm;
            end
            default: ;
        endcase
        if (cond)
        begin
            o.taken = 1'b1;
        end
        if (o.taken)
        begin
            o.npc = it.tgt;
        end
        if (o.wr)
        begin
            arch_regs[o.widx] = o.wval;
        end
        arch_pc = o.npc;
        return o;
    endfunction

    function automatic instr_t mk(logic [3:0] op, logic [4:0] rd, logic [4:0] ra,
                                  logic [4:0] rb, logic [31:0] imm, logic [6:0] off,
                                  logic given, logic [11:0] tgt);
        instr_t it;
        it.op = op; it.rd = rd; it.ra = ra; it.rb = rb;
        it.imm = imm; it.off = off; it.given = given; it.tgt = tgt;
        return it;
    endfunction

    // True when a load would not touch a word that was never stored
    function automatic bit load_is_defined(instr_t it);
        longint ea;
        ea = longint'($signed(arch_regs[it.ra])) + longint'(it.off);
        return (ea < 0 || ea >= MEM_WORDS) || data_mem_valid[ea];
    endfunction

    // Point a load at some stored word reachable from a register plus an offset
    function automatic bit aim_load(inout instr_t it);
        int unsigned first;
        int unsigned r;
        longint      a;
        first = $urandom_range(0, REGS - 1);
        for (int k = 0; k < REGS; k++)
        begin
            r = (first + k) % REGS;
            for (int o = 0; o < 100; o++)
            begin
                a = longint'($signed(arch_regs[r])) + o;
                if (a >= 0 && a < MEM_WORDS && data_mem_valid[a])
                begin
                    it.ra = 5'(r);
                    it.off = 7'(o);
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic instr_t random_instr();
        instr_t      it;
        int unsigned pick;
        int unsigned sel;
        it.rd = 5'($urandom_range(0, 31));
        it.ra = 5'($urandom_range(0, 31));
        it.rb = 5'($urandom_range(0, 31));
        it.imm = $urandom();
        it.off = 7'($urandom_range(0, 99));
        it.given = ($urandom_range(0, 9) != 0);
        it.tgt = 12'($urandom_range(0, 4095));
        pick = $urandom_range(0, 99);
        if (pick < 8)       it.op = rsu_pkg::OP_ADD;
        else if (pick < 14) it.op = rsu_pkg::OP_SUB;
        else if (pick < 24) it.op = rsu_pkg::OP_ADDI;
        else if (pick < 30) it.op = rsu_pkg::OP_BNE;
        else if (pick < 36) it.op = rsu_pkg::OP_BLT;
        else if (pick < 42) it.op = rsu_pkg::OP_BEQ;
        else if (pick < 56) it.op = rsu_pkg::OP_LW;
        else if (pick < 70) it.op = rsu_pkg::OP_SW;
        else if (pick < 74) it.op = rsu_pkg::OP_J;
        else if (pick < 78) it.op = rsu_pkg::OP_JAL;
        else if (pick < 82) it.op = rsu_pkg::OP_LA;
        else if (pick < 94) it.op = rsu_pkg::OP_LI;
        else if (pick < 97) it.op = rsu_pkg::OP_NOP;
        else                it.op = 4'($urandom_range(13, 15));

        // keep plenty of registers holding usable word addresses
        if (it.op == rsu_pkg::OP_LI)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 10)      it.imm = 32'($urandom_range(0, 160));
            else if (sel < 13) it.imm = 32'($urandom_range(3990, 4095));
            else if (sel < 15) it.imm = -32'($urandom_range(1, 128));
        end
        if (it.op == rsu_pkg::OP_ADDI && $urandom_range(0, 1))
        begin
            it.imm = 32'($urandom_range(0, 32)) - 32'd16;
        end
        if ((it.op == rsu_pkg::OP_BNE || it.op == rsu_pkg::OP_BLT ||
             it.op == rsu_pkg::OP_BEQ) && $urandom_range(0, 3) == 0)
        begin
            it.ra = it.rd;
        end
        // loads hit a stored word, fault, or turn into a store
        if (it.op == rsu_pkg::OP_LW && it.given)
        begin
            if ($urandom_range(0, 1) || !load_is_defined(it))
            begin
                void'(aim_load(it));
            end
            if (!load_is_defined(it))
            begin
                it.op = rsu_pkg::OP_SW;
            end
        end
        return it;
    endfunction

    task automatic queue_instr(instr_t it);
        job_t j;
        j.ins = it;
        j.res = execute_instr(it);
        if (it.op == rsu_pkg::OP_LW && j.res.wr) load_hits++;
        if (j.res.fault) addr_faults++;
        if (j.res.taken) redirects++;
        pending_instrs.push_back(j);
        queued_instrs++;
    endtask

    task automatic write_start_pc(logic [11:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        arch_pc = value;
        pc_settings++;
    endtask

    // Block until every queued instruction is accepted and its result checked
    task automatic wait_drained();
        @(posedge clk);
        while (accepted_instrs != queued_instrs || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Sender: offer queued instructions, with a random gap before each
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            expected_results.push_back(cur_job.res);
            accepted_instrs++;
        end
        if (!s_axis_tvalid || s_axis_tready)
        begin
            if (send_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_instrs.size() > 0)
            begin
                cur_job = pending_instrs.pop_front();
                s_axis_tdata <= {6'd0, cur_job.ins.tgt, cur_job.ins.off, cur_job.ins.imm,
                                 cur_job.ins.rb, cur_job.ins.ra, cur_job.ins.rd};
                s_axis_tuser <= {cur_job.ins.given, cur_job.ins.op};
                s_axis_tvalid <= 1'b1;
                if ($urandom_range(0, 29) == 0)
                begin
                    send_steady = !send_steady;
                end
                send_gap <= send_steady ? 0 : $urandom_range(0, 8);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: check each result against the oldest expectation, then stall
    always @(posedge clk)
    begin
        outcome_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual tdata %0h tuser %0h",
                         $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("next_pc", want.npc, m_axis_tdata[11:0]);
                check_field("written_index", want.widx, m_axis_tdata[16:12]);
                check_field("written_value", want.wval, m_axis_tdata[48:17]);
                check_field("reg_written", want.wr, m_axis_tuser[0]);
                check_field("branch_taken", want.taken, m_axis_tuser[1]);
                check_field("address_fault", want.fault, m_axis_tuser[2]);
                results_seen++;
            end
            if ($urandom_range(0, 29) == 0)
            begin
                recv_steady = !recv_steady;
            end
            recv_wait = recv_steady ? 0 : $urandom_range(0, 8);
        end
        else if (recv_wait > 0)
        begin
            recv_wait--;
        end
        m_axis_tready <= (recv_wait == 0) && (hold_left == 0);
    end

    // Hold the receiver off once for a long stretch so the pipeline backs up
    always @(posedge clk)
    begin
        if (!hold_done && accepted_instrs >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("[riscv_subset_execute_unit] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        for (int r = 0; r < REGS; r++)
        begin
            arch_regs[r] = '0;
        end
        for (int a = 0; a < MEM_WORDS; a++)
        begin
            data_mem_valid[a] = 1'b0;
        end
        arch_pc = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: start near the top so the pc wraps early
        write_start_pc(12'd4093);
        queue_instr(mk(rsu_pkg::OP_LI,   5'd1,  5'd0,  5'd0, 32'h7FFF_FFFF, 7'd0, 1'b1, 12'd0));
        queue_instr(mk(rsu_pkg::OP_LI,   5'd2,  5'd0,  5'd0, 32'h8000_0000, 7'd0, 1'b1, 12'd0));
        queue_instr(mk(rsu_pkg::OP_ADD,  5'd3,  5'd1,  5'd1, 32'd0, 7'd0, 1'b1, 12'd0));
        queue_instr(mk(rsu_pkg::OP_SUB,  5'd4,  5'd2,  5'd1, 32'd0, 7'd0, 1'b1, 12'd0));
        queue_instr(mk(rsu_pkg::OP_ADDI, 5'd5,  5'd1,  5'd0, 32'd1, 7'd0, 1'b1, 12'd0));
        queue_instr(mk(rsu_pkg::OP_LI,   5'd31, 5'd0,  5'd0, 32'd100, 7'd0, 1'b1, 12'd0));
        queue_instr(mk(rsu_pkg::OP_SW,   5'd0,  5'd31, 5'd1, 32'd0, 7'd99, 1'b1, 12'd0));
        queue_instr(mk(rsu_pkg::OP_LW,   5'd6,  5'd31, 5'd0, 32'd0, 7'd99, 1'b1, 12'd0));
        // no offset: loads and stores only advance the pc
        queue_instr(mk(rsu_pkg::OP_SW,   5'd0,  5'd31, 5'd2, 32'd0, 7'd5, 1'b0, 12'd0));
        queue_instr(mk(rsu_pkg::OP_LW,   5'd6,  5'd31, 5'd0, 32'd0, 7'd99, 1'b0, 12'd0));
        // negative and past-the-end addresses fault; the last word does not
        queue_instr(mk(rsu_pkg::OP_LI,   5'd7,  5'd0,  5'd0, 32'hFFFF_FFFF, 7'd0, 1'b1, 12'd0));
        queue_instr(mk(rsu_pkg::OP_SW,   5'd0,  5'd7,  5'd1, 32'd0, 7'd0, 1'b1, 12'd0));
        queue_instr(mk(rsu_pkg::OP_LW,   5'd6,  5'd7,  5'd0, 32'd0, 7'd0, 1'b1, 12'd0));
        queue_instr(mk(rsu_pkg::OP_LI,   5'd8,  5'd0,  5'd0, 32'd4000, 7'd0, 1'b1, 12'd0));
        queue_instr(mk(rsu_pkg::OP_LW,   5'd9,  5'd8,  5'd0, 32'd0, 7'd99, 1'b1, 12'd0));
        queue_instr(mk(rsu_pkg::OP_SW,   5'd0,  5'd8,  5'd2, 32'd0, 7'd95, 1'b1, 12'd0));
        queue_instr(mk(rsu_pkg::OP_LW,   5'd9,  5'd8,  5'd0, 32'd0, 7'd95, 1'b1, 12'd0));
        // branches, including a signed compare between the extreme values
        queue_instr(mk(rsu_pkg::OP_BNE,  5'd1,  5'd2,  5'd0, 32'd0, 7'd0, 1'b1, 12'd1234));
        queue_instr(mk(rsu_pkg::OP_BEQ,  5'd1,  5'd1,  5'd0, 32'd0, 7'd0, 1'b1, 12'd100));
        queue_instr(mk(rsu_pkg::OP_BLT,  5'd2,  5'd1,  5'd0, 32'd0, 7'd0, 1'b1, 12'hABC));
        queue_instr(mk(rsu_pkg::OP_BLT,  5'd1,  5'd2,  5'd0, 32'd0, 7'd0, 1'b1, 12'd0));
        // jal from the last pc links to one past the top; then la, li, add, nop and an unused op code
        queue_instr(mk(rsu_pkg::OP_J,    5'd0,  5'd0,  5'd0, 32'd0, 7'd0, 1'b1, 12'd4095));
        queue_instr(mk(rsu_pkg::OP_JAL,  5'd10, 5'd0,  5'd0, 32'd0, 7'd0, 1'b1, 12'd0));
        queue_instr(mk(rsu_pkg::OP_LA,   5'd11, 5'd0,  5'd0, 32'd0, 7'd0, 1'b1, 12'd4095));
        queue_instr(mk(rsu_pkg::OP_LI,   5'd0,  5'd0,  5'd0, 32'd5, 7'd0, 1'b1, 12'd0));
        queue_instr(mk(rsu_pkg::OP_ADD,  5'd12, 5'd0,  5'd0, 32'd0, 7'd0, 1'b1, 12'd0));
        queue_instr(mk(rsu_pkg::OP_NOP,  5'd0,  5'd0,  5'd0, 32'd0, 7'd0, 1'b1, 12'd0));
        queue_instr(mk(4'd15,   5'd13, 5'd1,  5'd1, 32'd0, 7'd0, 1'b1, 12'd77));
        wait_drained();

        // Random streams under the top, a random and the bottom start pc
        write_start_pc(12'd4095);
        for (int n = 0; n < 200; n++)
        begin
            queue_instr(random_instr());
        end
        wait_drained();

        write_start_pc(12'($urandom_range(1, 4094)));
        for (int n = 0; n < 175; n++)
        begin
            queue_instr(random_instr());
        end
        wait_drained();

        write_start_pc(12'd0);
        for (int n = 0; n < 175; n++)
        begin
            queue_instr(random_instr());
        end
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            errors++;
        end

        $display("Ran %0d instructions over %0d start pc values, %0d results checked",
                 accepted_instrs, pc_settings, results_seen);
        $display("Loads that hit %0d, address faults %0d, taken branches and jumps %0d",
                 load_hits, addr_faults, redirects);
        if (errors == 0)
        begin
            $display("[riscv_subset_execute_unit] OK");
        end
        else
        begin
            $display("[riscv_subset_execute_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rsu_pkg.sv
rtl/rsu_regfile.sv
rtl/rsu_dmem.sv
rtl/riscv_subset_execute_unit.sv
verif/testbench.sv
